### src/reader_writer_lock_unit_top_macros.svh
// Assertion macros for the lock unit.
`ifndef READER_WRITER_LOCK_UNIT_TOP_MACROS_SVH
`define READER_WRITER_LOCK_UNIT_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RWL_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define RWL_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);
`endif

### src/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and codes for the reader/writer lock unit.
// ----------------------------------------------------------------------------
package rwl_pkg;
   localparam int REQUESTERS = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int EXCLUSIVELOCK = 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int RW = $clog2(REQUESTERS);

   typedef enum logic [2:0] {
      OP_ACQUIRE = 3'd0, OP_RELEASE = 3'd1, OP_DEGRADE = 3'd2,
      OP_CANCEL = 3'd3, OP_ABANDON = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      EV_GRANTED = 4'd0, EV_QUEUED = 4'd1, EV_WOKEN = 4'd2, EV_RELEASED = 4'd3,
      EV_NOT_HOLDER = 4'd4, EV_DEGRADED = 4'd5, EV_REFUSED = 4'd6,
      EV_CANCELLED = 4'd7, EV_FULL = 4'd8
   } event_type;

   // Classified request passed from the front to the back.
   typedef struct packed {
      logic [2:0] op;
      logic [3:0] requester;
      logic       exclusive;
      logic       in_range;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DROP, ST_HEAD, ST_GRANT, ST_SCAN, ST_FINISH
   } state_type;
endpackage

### src/reader_writer_lock_unit_top.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_unit_top
// Shared/exclusive lock with a FIFO wait queue for 16 requesters.
// ----------------------------------------------------------------------------
// Usage: a request (op, requester, exclusive) is offered on the req_ channel
// and taken at a clock edge where req_valid is high and req_stall is low.
// Each request yields one or more results on the rsp_ channel, taken the same
// way with rsp_valid and rsp_stall; rsp_last marks the final result of a
// request. Unknown opcodes are taken and yield nothing.
// The front checks the opcode and the requester range and places the request
// in a two-entry command queue; req_stall is high only while both entries wait.
// The back runs one request at a time. An acquire, a refused request or a
// release with an empty wait queue goes from idle to one result state and
// back; its result is registered in the back and then in the output register.
// An in-range cancel, an in-range abandon by a non-holder, and a release,
// degrade or abandon that wakes waiters, walk the wait queue one entry per
// cycle while no result is stalled; the back takes no new request until the
// walk is done. Status flags on every result give the lock state after the
// whole request. Each result passes through one output register, so while
// rsp_stall is high the back waits and the front fills up. Reset clears the
// state, holders, exclusive flag, queue count and output valid flag.
// ----------------------------------------------------------------------------
`include "reader_writer_lock_unit_top_macros.svh"
module reader_writer_lock_unit_top
   import rwl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [3:0] req_requester,
   input  logic       req_exclusive,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_who,
   output logic [3:0] rsp_event_res,
   output logic       rsp_granted_exclusive,
   output logic       rsp_is_locked,
   output logic       rsp_is_exclusive,
   output logic       rsp_is_shared,
   output logic       rsp_last
);
   cmd_type    cmd;
   logic       cmd_valid, cmd_take;
   logic       b_valid, b_stall;
   logic [3:0] b_who, b_ev;
   logic       b_gx, b_lk, b_ex, b_sh, b_last;

   // Front: accepts and classifies requests.
   rwl_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_requester,
      .req_exclusive, .cmd_valid, .cmd_take, .cmd
   );

   // Back: runs each command and walks the wait queue.
   rwl_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .res_valid(b_valid), .res_stall(b_stall), .res_who(b_who),
      .res_event(b_ev), .res_gx(b_gx), .res_locked(b_lk), .res_excl(b_ex),
      .res_shared(b_sh), .res_last(b_last)
   );

   // Output register: holds each result; stalls the back while full and rsp_stall is high.
   rwl_out u_out (
      .clock, .reset, .in_valid(b_valid), .in_stall(b_stall),
      .in_who(b_who), .in_event(b_ev), .in_gx(b_gx), .in_locked(b_lk),
      .in_excl(b_ex), .in_shared(b_sh), .in_last(b_last),
      .rsp_valid, .rsp_stall, .rsp_who, .rsp_event_res, .rsp_granted_exclusive,
      .rsp_is_locked, .rsp_is_exclusive, .rsp_is_shared, .rsp_last
   );

   // An exclusive hold always has a holder.
   `RWL_ASSERT_IMP(a_excl_locked, clock, reset, rsp_valid && rsp_is_exclusive,
      rsp_is_locked, "exclusive without holder")
   // Shared and exclusive never show together.
   `RWL_ASSERT_IMP(a_excl_shared, clock, reset, rsp_valid,
      !(rsp_is_exclusive && rsp_is_shared), "shared and exclusive both set")
   // Grant flag appears only on grant events.
   `RWL_ASSERT_IMP(a_gx_event, clock, reset, rsp_valid && rsp_granted_exclusive,
      rsp_event_res == 4'(EV_GRANTED) || rsp_event_res == 4'(EV_WOKEN),
      "exclusive flag on non-grant")
   // A stalled result stays offered and unchanged.
   `RWL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_who) && $stable(rsp_event_res) && $stable(rsp_last),
      "stalled result changed")
endmodule

### src/rwl_front.sv
// ----------------------------------------------------------------------------
// rwl_front
// Accepts requests, drops unknown opcodes and queues commands for the back.
// ----------------------------------------------------------------------------
module rwl_front
   import rwl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [3:0] req_requester,
   input  logic       req_exclusive,
   output logic       cmd_valid,
   input  logic       cmd_take,
   output cmd_type    cmd
);
   // Two-entry command queue.
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr;
   logic       rd;
   logic       known;

   assign req_stall = (cnt_ff == 2'd2);
   assign known = (req_op <= 3'(OP_ABANDON));
   assign wr = req_valid && !req_stall && known;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign rd = cmd_valid && cmd_take;
   assign cmd = q_ff[0];

   always_comb begin
      cmd_type n;
      n.op = req_op;
      n.requester = req_requester;
      n.exclusive = req_exclusive;
      n.in_range = ({1'b0, req_requester} < 5'(REQUESTERS));
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (rd) begin
         q_in[0] = q_ff[1];
      end
      if (wr) begin
         if ((cnt_ff - 2'(rd)) == 2'd0) q_in[0] = n;
         else q_in[1] = n;
      end
      cnt_in = cnt_ff + 2'(wr) - 2'(rd);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end
endmodule

### src/rwl_back.sv
// ----------------------------------------------------------------------------
// rwl_back
// Executes commands on the lock state and emits at most one result per cycle.
// ----------------------------------------------------------------------------
module rwl_back
   import rwl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_take,
   input  cmd_type    cmd,
   output logic       res_valid,
   input  logic       res_stall,
   output logic [3:0] res_who,
   output logic [3:0] res_event,
   output logic       res_gx,
   output logic       res_locked,
   output logic       res_excl,
   output logic       res_shared,
   output logic       res_last
);
   localparam int CW = QW + 1;

   state_type state_ff, state_in;
   logic [REQUESTERS-1:0] hold_ff, hold_in;
   logic excl_ff, excl_in;
   // Queue entries: requester and exclusive bit, kept in flip-flops and
   // compacted in place by one read/write pointer pass.
   logic [3:0] qr_ff [QUEUE_DEPTH];
   logic       qx_ff [QUEUE_DEPTH];
   logic [3:0] qr_in [QUEUE_DEPTH];
   logic       qx_in [QUEUE_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [3:0] who_ff, who_in;
   // Answer to the request itself.
   logic [3:0] ev_ff, ev_in;
   logic       gx_ff, gx_in;
   // Wake-up plan: queue entries still to be granted and the final status.
   logic [QUEUE_DEPTH-1:0] mask_ff, mask_in;
   logic       fin_lk_ff, fin_lk_in, fin_ex_ff, fin_ex_in;

   logic [RW-1:0] ri;
   logic          is_hold, go_wake, go_drop;
   logic          take_head, excl_after, scan_end;
   logic [QUEUE_DEPTH-1:0] share, mask_left;
   logic [REQUESTERS-1:0]  fin_hold;
   logic [QW-1:0] ra, wa;

   assign ri = cmd.requester[RW-1:0];
   assign is_hold = cmd.in_range && hold_ff[ri];
   assign go_wake = is_hold && (cmd.op == OP_RELEASE || cmd.op == OP_ABANDON ||
                                (cmd.op == OP_DEGRADE && excl_ff));
   assign go_drop = cmd.in_range && !go_wake &&
                    (cmd.op == OP_CANCEL || cmd.op == OP_ABANDON);

   assign ra = rp_ff[QW-1:0];
   assign wa = wp_ff[QW-1:0];
   assign scan_end = (rp_ff == count_ff);
   assign mask_left = mask_ff & ~(QUEUE_DEPTH'(1) << ra);

   // The head is granted only when nobody holds; every other shared
   // waiter is granted unless the head took the lock exclusively.
   assign take_head = (count_ff != '0) && (hold_ff == '0);
   assign excl_after = take_head && qx_ff[0];

   always_comb begin
      share = '0;
      fin_hold = hold_ff;
      if (take_head) fin_hold[qr_ff[0][RW-1:0]] = 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (CW'(i) < count_ff && !qx_ff[i] && !excl_after && !(take_head && i == 0)) begin
            share[i] = 1'b1;
            fin_hold[qr_ff[i][RW-1:0]] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (cmd_valid) begin
            if (go_wake) state_in = ST_HEAD;
            else if (go_drop) state_in = ST_DROP;
            else state_in = ST_FINISH;
         end
         ST_DROP: if (scan_end) state_in = ST_FINISH;
         ST_HEAD: if (!res_stall) begin
            if (take_head) state_in = ST_GRANT;
            else if (share != '0) state_in = ST_SCAN;
            else state_in = ST_IDLE;
         end
         ST_GRANT: if (!res_stall) state_in = ST_SCAN;
         ST_SCAN: if (scan_end) state_in = ST_IDLE;
         ST_FINISH: if (!res_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      res_valid = 1'b0;
      res_who = who_ff;
      res_event = ev_ff;
      res_gx = 1'b0;
      res_locked = fin_lk_ff;
      res_excl = fin_ex_ff;
      res_last = 1'b0;
      cmd_take = (state_ff == ST_IDLE);
      case (state_ff)
         ST_FINISH: begin
            res_valid = 1'b1; res_gx = gx_ff; res_last = 1'b1;
            res_locked = |hold_ff; res_excl = excl_ff;
         end
         ST_HEAD: begin
            res_valid = 1'b1;
            res_locked = |fin_hold; res_excl = excl_after;
            res_last = !take_head && (share == '0);
         end
         ST_GRANT: begin
            res_valid = 1'b1; res_who = qr_ff[0]; res_event = EV_WOKEN;
            res_gx = qx_ff[0]; res_last = (mask_ff == '0);
         end
         ST_SCAN: if (!scan_end && mask_ff[ra]) begin
            res_valid = 1'b1; res_who = qr_ff[ra]; res_event = EV_WOKEN;
            res_last = (mask_left == '0);
         end
         default: ;
      endcase
      res_shared = !res_excl && res_locked;
   end

   always_comb begin
      hold_in = hold_ff; excl_in = excl_ff;
      qr_in = qr_ff; qx_in = qx_ff;
      count_in = count_ff; rp_in = rp_ff; wp_in = wp_ff;
      who_in = who_ff; ev_in = ev_ff; gx_in = gx_ff;
      mask_in = mask_ff; fin_lk_in = fin_lk_ff; fin_ex_in = fin_ex_ff;
      case (state_ff)
         ST_IDLE: if (cmd_valid) begin
            who_in = cmd.requester;
            gx_in = 1'b0;
            rp_in = '0; wp_in = '0;
            if (go_wake) begin
               excl_in = 1'b0;
               if (cmd.op == OP_DEGRADE) ev_in = EV_DEGRADED;
               else begin
                  ev_in = EV_RELEASED; hold_in[ri] = 1'b0;
               end
            end else if (go_drop) begin
               ev_in = EV_CANCELLED;
            end else begin
               case (cmd.op)
                  OP_ACQUIRE: begin
                     if (!cmd.in_range) ev_in = EV_FULL;
                     else if ((cmd.exclusive == 1'(EXCLUSIVELOCK)) ? (hold_ff == '0)
                                                                  : !excl_ff) begin
                        ev_in = EV_GRANTED; gx_in = cmd.exclusive;
                        hold_in[ri] = 1'b1;
                        if (cmd.exclusive) excl_in = 1'b1;
                     end else if (count_ff >= CW'(QUEUE_DEPTH)) ev_in = EV_FULL;
                     else begin
                        ev_in = EV_QUEUED;
                        qr_in[count_ff[QW-1:0]] = cmd.requester;
                        qx_in[count_ff[QW-1:0]] = cmd.exclusive;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_RELEASE: ev_in = EV_NOT_HOLDER;
                  OP_DEGRADE: ev_in = EV_REFUSED;
                  OP_CANCEL: ev_in = EV_CANCELLED;
                  default: ev_in = EV_NOT_HOLDER;
               endcase
            end
         end
         ST_DROP: begin
            if (scan_end) count_in = wp_ff;
            else begin
               if (qr_ff[ra] != who_ff) begin
                  qr_in[wa] = qr_ff[ra]; qx_in[wa] = qx_ff[ra];
                  wp_in = wp_ff + CW'(1);
               end
               rp_in = rp_ff + CW'(1);
            end
         end
         ST_HEAD: if (!res_stall) begin
            fin_lk_in = |fin_hold; fin_ex_in = excl_after; mask_in = share;
         end
         ST_GRANT: if (!res_stall) begin
            hold_in[qr_ff[0][RW-1:0]] = 1'b1;
            excl_in = qx_ff[0];
            rp_in = CW'(1);
         end
         ST_SCAN: begin
            if (scan_end) count_in = wp_ff;
            else if (mask_ff[ra]) begin
               if (!res_stall) begin
                  hold_in[qr_ff[ra][RW-1:0]] = 1'b1;
                  mask_in = mask_left;
                  rp_in = rp_ff + CW'(1);
               end
            end else begin
               // Waiters not granted stay, moved down over the granted ones.
               qr_in[wa] = qr_ff[ra]; qx_in[wa] = qx_ff[ra];
               wp_in = wp_ff + CW'(1); rp_in = rp_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      qr_ff <= qr_in; qx_ff <= qx_in;
      rp_ff <= rp_in; wp_ff <= wp_in; who_ff <= who_in;
      ev_ff <= ev_in; gx_ff <= gx_in; mask_ff <= mask_in;
      fin_lk_ff <= fin_lk_in; fin_ex_ff <= fin_ex_in;
      if (reset) begin
         state_ff <= ST_IDLE; hold_ff <= '0; excl_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in; hold_ff <= hold_in; excl_ff <= excl_in;
         count_ff <= count_in;
      end
   end
endmodule

### src/rwl_out.sv
// ----------------------------------------------------------------------------
// rwl_out
// Output register between the back stage and the result channel.
// ----------------------------------------------------------------------------
module rwl_out (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  logic [3:0] in_who,
   input  logic [3:0] in_event,
   input  logic       in_gx,
   input  logic       in_locked,
   input  logic       in_excl,
   input  logic       in_shared,
   input  logic       in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_who,
   output logic [3:0] rsp_event_res,
   output logic       rsp_granted_exclusive,
   output logic       rsp_is_locked,
   output logic       rsp_is_exclusive,
   output logic       rsp_is_shared,
   output logic       rsp_last
);
   logic       hv_ff, hv_in;
   logic [3:0] hw_ff, hw_in, he_ff, he_in;
   logic       hg_ff, hg_in, hk_ff, hk_in, hx_ff, hx_in;
   logic       hs_ff, hs_in, hl_ff, hl_in;
   logic       take;

   // A new result enters when the register is empty or drains this cycle.
   assign in_stall = hv_ff && rsp_stall;
   assign take = in_valid && !in_stall;
   assign rsp_valid = hv_ff;
   assign rsp_who = hw_ff;
   assign rsp_event_res = he_ff;
   assign rsp_granted_exclusive = hg_ff;
   assign rsp_is_locked = hk_ff;
   assign rsp_is_exclusive = hx_ff;
   assign rsp_is_shared = hs_ff;
   assign rsp_last = hl_ff;

   always_comb begin
      hv_in = hv_ff && rsp_stall;
      hw_in = hw_ff; he_in = he_ff; hg_in = hg_ff; hk_in = hk_ff;
      hx_in = hx_ff; hs_in = hs_ff; hl_in = hl_ff;
      if (take) begin
         hv_in = 1'b1; hw_in = in_who; he_in = in_event; hg_in = in_gx;
         hk_in = in_locked; hx_in = in_excl; hs_in = in_shared; hl_in = in_last;
      end
   end

   always_ff @(posedge clock) begin
      hw_ff <= hw_in; he_ff <= he_in; hg_ff <= hg_in; hk_ff <= hk_in;
      hx_ff <= hx_in; hs_ff <= hs_in; hl_ff <= hl_in;
      if (reset) hv_ff <= 1'b0;
      else hv_ff <= hv_in;
   end
endmodule
